### rtl/core/rbca_pkg.sv
// Shared types and constants for the ring buffer with commit and acknowledge.
package rbca_pkg;

    localparam int CNT_W        = 12;
    localparam int PREFIX_BYTES = 4;

    localparam logic [CNT_W-1:0] LEN_MAX = '1;

    localparam logic [2:0] MODE_WSTART = 3'd0;
    localparam logic [2:0] MODE_WBYTE  = 3'd1;
    localparam logic [2:0] MODE_COMMIT = 3'd2;
    localparam logic [2:0] MODE_RSTART = 3'd3;
    localparam logic [2:0] MODE_RBYTE  = 3'd4;
    localparam logic [2:0] MODE_ACK    = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOSPACE  = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_TOOSMALL = 2'd3;

    localparam logic [1:0] WSEL_DATA   = 2'd0;
    localparam logic [1:0] WSEL_CNT_LO = 2'd1;
    localparam logic [1:0] WSEL_CNT_HI = 2'd2;
    localparam logic [1:0] WSEL_ZERO   = 2'd3;

    localparam logic [1:0] RES_PLAIN   = 2'd0;
    localparam logic [1:0] RES_BYTE    = 2'd1;
    localparam logic [1:0] RES_LEN_RAW = 2'd2;
    localparam logic [1:0] RES_LEN_PRE = 2'd3;

    typedef struct packed {
        logic       cnt_load;
        logic       sw_rewind;
        logic       sr_rewind;
        logic       wr_byte;
        logic [1:0] wsel;
        logic       rd_byte;
        logic       pre_cap;
        logic [1:0] pre_slot;
        logic       commit_w;
        logic       commit_r;
        logic       res_load;
        logic [1:0] res_sel;
        logic [1:0] res_status;
    } t_dp_cmd;

    typedef struct packed {
        logic prefix_en;
        logic space_ok;
        logic wb_full;
        logic ring_empty;
        logic rd_empty;
    } t_dp_stat;

endpackage

### rtl/core/rbca_dp.sv
// Datapath: ring memory, read and write positions, length logic and result registers.
module rbca_dp import rbca_pkg::*; #(
    parameter int DEPTH = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  logic [7:0]       i_data_byte,
    input  logic [CNT_W-1:0] i_byte_count,
    output t_dp_stat         o_stat,
    output logic [1:0]       o_status,
    output logic [7:0]       o_data_out,
    output logic [CNT_W-1:0] o_message_length
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = ((AW > CNT_W) ? AW : CNT_W) + 1;

    logic [7:0]       r_mem [0:DEPTH-1];
    logic [AW-1:0]    r_cw, r_cr, r_sw, r_sr;
    logic [AW-1:0]    n_cw, n_cr, n_sw, n_sr;
    logic             r_prefix_en;
    logic [7:0]       r_rdata, r_pre0, r_pre1, r_pre2;
    logic [CNT_W-1:0] r_count;
    logic [1:0]       r_status;
    logic [7:0]       r_data_out;
    logic [CNT_W-1:0] r_mlen;

    logic [CW-1:0]    free_sp, need, wrap_len, n_raw;
    logic             raw_small, pre_hi, pre_small;
    logic [CNT_W-1:0] raw_len, pre_lo, pre_len;
    logic [7:0]       wdata;

    function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_comb begin
        if (r_cw >= r_cr) begin
            free_sp = CW'(DEPTH - 1) - (CW'(r_cw) - CW'(r_cr));
        end else begin
            free_sp = CW'(r_cr) - CW'(r_cw) - CW'(1);
        end
        need = CW'(i_byte_count) + (r_prefix_en ? CW'(PREFIX_BYTES) : '0);

        wrap_len = CW'(DEPTH) - (CW'(r_cr) - CW'(r_cw));
        if (r_cw > r_cr) begin
            n_raw = CW'(r_cw) - CW'(r_cr);
        end else if (wrap_len > CW'(i_byte_count)) begin
            n_raw = CW'(i_byte_count);
        end else begin
            n_raw = wrap_len;
        end
        raw_small = CW'(i_byte_count) < n_raw;
        raw_len   = (n_raw > CW'(LEN_MAX)) ? LEN_MAX : n_raw[CNT_W-1:0];

        pre_hi    = (r_pre1[7:4] != 4'd0) || (r_pre2 != 8'd0) || (r_rdata != 8'd0);
        pre_lo    = {r_pre1[3:0], r_pre0};
        pre_small = pre_hi || (r_count < pre_lo);
        pre_len   = pre_hi ? LEN_MAX : pre_lo;

        case (i_cmd.wsel)
            WSEL_DATA:   wdata = i_data_byte;
            WSEL_CNT_LO: wdata = r_count[7:0];
            WSEL_CNT_HI: wdata = {4'd0, r_count[CNT_W-1:8]};
            default:     wdata = 8'd0;
        endcase
    end

    always_comb begin
        n_sw = r_sw;
        if (i_cmd.sw_rewind) begin
            n_sw = r_cw;
        end else if (i_cmd.wr_byte) begin
            n_sw = next_pos(r_sw);
        end
        n_sr = r_sr;
        if (i_cmd.sr_rewind) begin
            n_sr = r_cr;
        end else if (i_cmd.rd_byte) begin
            n_sr = next_pos(r_sr);
        end
        n_cw = i_cmd.commit_w ? r_sw : r_cw;
        n_cr = i_cmd.commit_r ? r_sr : r_cr;
    end

    assign o_stat.prefix_en  = r_prefix_en;
    assign o_stat.space_ok   = need <= free_sp;
    assign o_stat.wb_full    = next_pos(r_sw) == r_cr;
    assign o_stat.ring_empty = r_cw == r_cr;
    assign o_stat.rd_empty   = r_sr == r_cw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cw        <= '0;
            r_cr        <= '0;
            r_sw        <= '0;
            r_sr        <= '0;
            r_prefix_en <= 1'b0;
        end else begin
            r_cw <= n_cw;
            r_cr <= n_cr;
            r_sw <= n_sw;
            r_sr <= n_sr;
            if (i_cfg_we) begin
                r_prefix_en <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_byte) begin
            r_mem[r_sw] <= wdata;
        end
        if (i_cmd.rd_byte) begin
            r_rdata <= r_mem[r_sr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_load) begin
            r_count <= i_byte_count;
        end
        if (i_cmd.pre_cap) begin
            case (i_cmd.pre_slot)
                2'd0:    r_pre0 <= r_rdata;
                2'd1:    r_pre1 <= r_rdata;
                default: r_pre2 <= r_rdata;
            endcase
        end
        if (i_cmd.res_load) begin
            case (i_cmd.res_sel)
                RES_PLAIN: begin
                    r_status   <= i_cmd.res_status;
                    r_data_out <= 8'd0;
                    r_mlen     <= '0;
                end
                RES_BYTE: begin
                    r_status   <= ST_OK;
                    r_data_out <= r_rdata;
                    r_mlen     <= '0;
                end
                RES_LEN_RAW: begin
                    r_status   <= raw_small ? ST_TOOSMALL : ST_OK;
                    r_data_out <= 8'd0;
                    r_mlen     <= raw_len;
                end
                default: begin
                    r_status   <= pre_small ? ST_TOOSMALL : ST_OK;
                    r_data_out <= 8'd0;
                    r_mlen     <= pre_len;
                end
            endcase
        end
    end

    assign o_status         = r_status;
    assign o_data_out       = r_data_out;
    assign o_message_length = r_mlen;

endmodule

### rtl/core/rbca_ctrl.sv
// Controller: decodes each item and sequences prefix writes, prefix reads and byte reads.
module rbca_ctrl import rbca_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [2:0] i_mode,
    input  t_dp_stat   i_stat,
    output logic       o_busy,
    output logic       o_strobe,
    output t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PWR  = 3'd1;
    localparam logic [2:0] S_PRD  = 3'd2;
    localparam logic [2:0] S_PCAP = 3'd3;
    localparam logic [2:0] S_RBW  = 3'd4;

    logic [2:0] r_state, n_state;
    logic [1:0] r_cnt, n_cnt;
    logic       r_strobe;
    t_dp_cmd    cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                n_cnt = 2'd0;
                if (i_start) begin
                    cmd.cnt_load = 1'b1;
                    cmd.res_sel  = RES_PLAIN;
                    case (i_mode)
                        MODE_WSTART: begin
                            if (!i_stat.space_ok) begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = ST_NOSPACE;
                            end else begin
                                cmd.sw_rewind = 1'b1;
                                if (i_stat.prefix_en) begin
                                    n_state = S_PWR;
                                end else begin
                                    cmd.res_load = 1'b1;
                                end
                            end
                        end
                        MODE_WBYTE: begin
                            cmd.res_load = 1'b1;
                            if (i_stat.wb_full) begin
                                cmd.res_status = ST_NOSPACE;
                            end else begin
                                cmd.wr_byte = 1'b1;
                                cmd.wsel    = WSEL_DATA;
                            end
                        end
                        MODE_COMMIT: begin
                            cmd.commit_w = 1'b1;
                            cmd.res_load = 1'b1;
                        end
                        MODE_RSTART: begin
                            if (i_stat.ring_empty) begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = ST_EMPTY;
                            end else begin
                                cmd.sr_rewind = 1'b1;
                                if (i_stat.prefix_en) begin
                                    n_state = S_PRD;
                                end else begin
                                    cmd.res_load = 1'b1;
                                    cmd.res_sel  = RES_LEN_RAW;
                                end
                            end
                        end
                        MODE_RBYTE: begin
                            if (i_stat.rd_empty) begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = ST_EMPTY;
                            end else begin
                                cmd.rd_byte = 1'b1;
                                n_state     = S_RBW;
                            end
                        end
                        MODE_ACK: begin
                            cmd.commit_r = 1'b1;
                            cmd.res_load = 1'b1;
                        end
                        default: begin
                            cmd.res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_PWR: begin
                cmd.wr_byte = 1'b1;
                case (r_cnt)
                    2'd0:    cmd.wsel = WSEL_CNT_LO;
                    2'd1:    cmd.wsel = WSEL_CNT_HI;
                    default: cmd.wsel = WSEL_ZERO;
                endcase
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_PLAIN;
                    n_state      = S_IDLE;
                end
            end
            S_PRD: begin
                cmd.rd_byte  = 1'b1;
                cmd.pre_cap  = r_cnt != 2'd0;
                cmd.pre_slot = r_cnt - 2'd1;
                n_cnt        = r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    n_state = S_PCAP;
                end
            end
            S_PCAP: begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_LEN_PRE;
                n_state      = S_IDLE;
            end
            S_RBW: begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_BYTE;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= 2'd0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_strobe <= cmd.res_load;
        end
    end

    always_comb begin
        o_cmd = cmd;
        if (!i_rst_n) begin
            o_cmd = '0;
        end
    end

    assign o_busy   = r_state != S_IDLE;
    assign o_strobe = r_strobe;

endmodule

### rtl/core/ring_buffer_with_commit_and_ack.sv
// Top level of the byte ring buffer with two-phase write, commit, read and acknowledge.
//
//   Channel  | Ports                                          | Handshake
//   ---------+------------------------------------------------+-----------------------------
//   item in  | i_mode, i_data_byte, i_byte_count              | start high, busy low
//   result   | o_status, o_data_out, o_message_length         | o_strobe, one cycle, no stall
//   config   | i_cfg_we, i_cfg_wdata                          | write when i_cfg_we is high
//
// Write byte, commit, ack, failed starts and a start without prefix complete in the cycle they are accepted.
// A read byte passes through S_RBW because the ring memory read data is registered.
// A write start with prefix writes the prefix bytes in S_PWR on the memory write port.
// A read start with prefix reads the prefix bytes in S_PRD on the memory read port, then S_PCAP loads the length.
// Reset is synchronous and clears the four positions and the prefix enable.
// The result appears the cycle after its item finishes; the receiver cannot stall it.
module ring_buffer_with_commit_and_ack import rbca_pkg::*; #(
    parameter int DEPTH = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [2:0]       i_mode,
    input  logic [7:0]       i_data_byte,
    input  logic [CNT_W-1:0] i_byte_count,
    output logic             o_strobe,
    output logic [1:0]       o_status,
    output logic [7:0]       o_data_out,
    output logic [CNT_W-1:0] o_message_length,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    rbca_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_mode   (i_mode),
        .i_stat   (stat),
        .o_busy   (busy),
        .o_strobe (o_strobe),
        .o_cmd    (cmd)
    );

    rbca_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_data_byte      (i_data_byte),
        .i_byte_count     (i_byte_count),
        .o_stat           (stat),
        .o_status         (o_status),
        .o_data_out       (o_data_out),
        .o_message_length (o_message_length)
    );

    a_single_cycle_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_mode == MODE_WBYTE || i_mode == MODE_COMMIT ||
        i_mode == MODE_ACK) |=> o_strobe && !busy)
        else $error("single-cycle item did not produce a result");

    a_fail_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status == ST_NOSPACE || o_status == ST_EMPTY) |->
        o_data_out == 8'd0 && o_message_length == '0)
        else $error("failed item carries nonzero data");

    a_strobe_follows_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy) || $past(busy))
        else $error("result strobe without an item in progress");

endmodule

### sim/rbca_result_check.sv
// Result predictor and comparator for the ring buffer with commit and acknowledge.
module rbca_result_check import rbca_pkg::*; #(
    parameter int DEPTH = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  logic [2:0]       i_mode,
    input  logic [7:0]       i_data_byte,
    input  logic [CNT_W-1:0] i_byte_count,
    input  logic             i_strobe,
    input  logic [1:0]       i_status,
    input  logic [7:0]       i_data_out,
    input  logic [CNT_W-1:0] i_message_length,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_backlog
);
    localparam int POS_W = $clog2(DEPTH);

    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       data_out;
        logic [CNT_W-1:0] message_length;
    } ring_reply_t;

    logic [7:0]       ring_mem [DEPTH];
    logic [POS_W-1:0] wr_commit;
    logic [POS_W-1:0] rd_commit;
    logic [POS_W-1:0] wr_stage;
    logic [POS_W-1:0] rd_stage;
    logic             prefix_on;
    ring_reply_t      replies_due [$];
    int               fail_total = 0;

    function automatic logic [POS_W-1:0] step_pos(input logic [POS_W-1:0] p);
        return (int'(p) == DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    function automatic int free_bytes();
        int w;
        int r;
        w = int'(wr_commit);
        r = int'(rd_commit);
        return (w >= r) ? DEPTH - (w - r) - 1 : r - w - 1;
    endfunction

    function automatic void stage_byte(input logic [7:0] b);
        ring_mem[wr_stage] = b;
        wr_stage = step_pos(wr_stage);
    endfunction

    function automatic logic [7:0] fetch_byte();
        logic [7:0] b;
        b = ring_mem[rd_stage];
        rd_stage = step_pos(rd_stage);
        return b;
    endfunction

    function automatic ring_reply_t apply_item(input logic [2:0] m, input logic [7:0] d,
                                               input logic [CNT_W-1:0] c);
        ring_reply_t r;
        int          need;
        logic [31:0] n;
        r = '0;
        r.status = ST_OK;
        case (m)
            MODE_WSTART: begin
                need = int'(c) + (prefix_on ? PREFIX_BYTES : 0);
                if (need > free_bytes()) begin
                    r.status = ST_NOSPACE;
                end else begin
                    wr_stage = wr_commit;
                    if (prefix_on) begin
                        stage_byte(c[7:0]);
                        stage_byte(8'(c >> 8));
                        stage_byte(8'h00);
                        stage_byte(8'h00);
                    end
                end
            end
            MODE_WBYTE: begin
                if (step_pos(wr_stage) == rd_commit) begin
                    r.status = ST_NOSPACE;
                end else begin
                    stage_byte(d);
                end
            end
            MODE_COMMIT: begin
                wr_commit = wr_stage;
            end
            MODE_RSTART: begin
                if (wr_commit == rd_commit) begin
                    r.status = ST_EMPTY;
                end else begin
                    rd_stage = rd_commit;
                    if (prefix_on) begin
                        n[7:0]   = fetch_byte();
                        n[15:8]  = fetch_byte();
                        n[23:16] = fetch_byte();
                        n[31:24] = fetch_byte();
                    end else if (int'(wr_commit) > int'(rd_stage)) begin
                        n = 32'(int'(wr_commit) - int'(rd_stage));
                    end else begin
                        // The data wraps, so the count is clipped to the reader capacity.
                        n = 32'(int'(wr_commit) + DEPTH - int'(rd_stage));
                        if (n > 32'(c)) begin
                            n = 32'(c);
                        end
                    end
                    if (32'(c) < n) begin
                        r.status = ST_TOOSMALL;
                    end
                    r.message_length = (n > 32'(LEN_MAX)) ? LEN_MAX : n[CNT_W-1:0];
                end
            end
            MODE_RBYTE: begin
                if (rd_stage == wr_commit) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data_out = fetch_byte();
                end
            end
            MODE_ACK: begin
                rd_commit = rd_stage;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        ring_reply_t due;
        if (!i_rst_n) begin
            wr_commit = '0;
            rd_commit = '0;
            wr_stage  = '0;
            rd_stage  = '0;
            prefix_on = 1'b0;
            replies_due.delete();
        end else begin
            if (i_strobe) begin
                if (replies_due.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10) begin
                        $display("unexpected ring result at %0t: status %0d data %02h length %0d",
                                 $time, i_status, i_data_out, i_message_length);
                    end
                end else begin
                    due = replies_due.pop_front();
                    if (due.status !== i_status || due.data_out !== i_data_out ||
                        due.message_length !== i_message_length) begin
                        fail_total++;
                        if (fail_total <= 10) begin
                            $display({"ring result mismatch at %0t: status %0d/%0d ",
                                      "data %02h/%02h length %0d/%0d (expected/actual)"},
                                     $time, due.status, i_status, due.data_out, i_data_out,
                                     due.message_length, i_message_length);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                prefix_on = i_cfg_wdata;
            end
            if (i_start && !i_busy) begin
                replies_due.push_back(apply_item(i_mode, i_data_byte, i_byte_count));
            end
        end
        o_pending    <= replies_due.size();
        o_backlog    <= (int'(wr_commit) - int'(rd_commit) + DEPTH) % DEPTH;
        o_fail_count <= fail_total;
    end

endmodule

### sim/ring_buffer_with_commit_and_ack_tb.sv
// Testbench top that drives items and configuration into the ring buffer and gives the verdict.
module ring_buffer_with_commit_and_ack_tb;
    import rbca_pkg::*;

    localparam int DEPTH          = 4096;
    localparam int CYCLE_LIMIT    = 1_500_000;
    localparam int SETTLE         = 10;
    localparam int PHASE_ITEMS    = 160;
    localparam int SMALL_MSG_MAX  = 24;
    localparam int LARGE_MSG_MAX  = 200;

    localparam logic [2:0] MODE_UNUSED_A = 3'd6;
    localparam logic [2:0] MODE_UNUSED_B = 3'd7;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [2:0]       i_mode;
    logic [7:0]       i_data_byte;
    logic [CNT_W-1:0] i_byte_count;
    logic             o_strobe;
    logic [1:0]       o_status;
    logic [7:0]       o_data_out;
    logic [CNT_W-1:0] o_message_length;
    logic             i_cfg_we;
    logic             i_cfg_wdata;

    int   fail_count;
    int   pending;
    int   backlog;
    int   cycle_count = 0;
    int   items_sent;
    int   msg_lens [$];
    int   queued_bytes;
    logic prefix_on;
    bit   no_gaps;

    ring_buffer_with_commit_and_ack #(.DEPTH(DEPTH)) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_mode           (i_mode),
        .i_data_byte      (i_data_byte),
        .i_byte_count     (i_byte_count),
        .o_strobe         (o_strobe),
        .o_status         (o_status),
        .o_data_out       (o_data_out),
        .o_message_length (o_message_length),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    rbca_result_check #(.DEPTH(DEPTH)) u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_mode           (i_mode),
        .i_data_byte      (i_data_byte),
        .i_byte_count     (i_byte_count),
        .i_strobe         (o_strobe),
        .i_status         (o_status),
        .i_data_out       (o_data_out),
        .i_message_length (o_message_length),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_backlog        (backlog)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL ring_buffer_with_commit_and_ack");
            $finish;
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [CNT_W-1:0] rand_count();
        return CNT_W'($urandom_range(int'(LEN_MAX)));
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_gaps) begin
            return 0;
        end
        r = $urandom_range(99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(30, 5);
    endfunction

    task automatic send_item(input logic [2:0] m, input logic [7:0] d,
                             input logic [CNT_W-1:0] c);
        int gap;
        start        <= 1'b1;
        i_mode       <= m;
        i_data_byte  <= d;
        i_byte_count <= c;
        do @(posedge i_clk); while (busy);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        if (start) begin
            start <= 1'b0;
        end
        do @(posedge i_clk); while (pending != 0 || busy);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_prefix(input logic en);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= en;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        prefix_on = en;
    endtask

    task automatic drain_ring();
        int left;
        wait_idle();
        left = backlog;
        if (left > 0) begin
            send_item(MODE_RSTART, rand_byte(), LEN_MAX);
            repeat (left) send_item(MODE_RBYTE, rand_byte(), rand_count());
            send_item(MODE_ACK, rand_byte(), rand_count());
            wait_idle();
        end
        msg_lens.delete();
        queued_bytes = 0;
    endtask

    task automatic write_message();
        int room;
        int len;
        int kind;
        room = DEPTH - 1 - queued_bytes - (prefix_on ? PREFIX_BYTES : 0);
        kind = $urandom_range(19);
        if (room < 0 || (kind == 0 && room < int'(LEN_MAX))) begin
            send_item(MODE_WSTART, rand_byte(),
                      CNT_W'($urandom_range(int'(LEN_MAX), (room < 0) ? 0 : room + 1)));
            return;
        end
        if ($urandom_range(99) < 3) begin
            len = $urandom_range((room > LARGE_MSG_MAX) ? LARGE_MSG_MAX : room);
        end else begin
            len = $urandom_range((room > SMALL_MSG_MAX) ? SMALL_MSG_MAX : room);
        end
        send_item(MODE_WSTART, rand_byte(), CNT_W'(len));
        repeat (len) send_item(MODE_WBYTE, rand_byte(), rand_count());
        if (kind != 1) begin
            send_item(MODE_COMMIT, rand_byte(), rand_count());
            msg_lens.push_back(len);
            queued_bytes += len + (prefix_on ? PREFIX_BYTES : 0);
        end
    endtask

    task automatic read_message();
        int len;
        int cap;
        int kind;
        if (msg_lens.size() == 0) begin
            send_item(MODE_RSTART, rand_byte(), rand_count());
            send_item(MODE_RBYTE, rand_byte(), rand_count());
            return;
        end
        len  = msg_lens[0];
        kind = $urandom_range(9);
        if (kind < 2 && len > 0) begin
            cap = $urandom_range(len - 1);
        end else begin
            cap = $urandom_range((len + 20 > int'(LEN_MAX)) ? int'(LEN_MAX) : len + 20, len);
        end
        send_item(MODE_RSTART, rand_byte(), CNT_W'(cap));
        repeat (len) send_item(MODE_RBYTE, rand_byte(), rand_count());
        if (kind == 2 && msg_lens.size() == 1) begin
            send_item(MODE_RBYTE, rand_byte(), rand_count());
        end
        if (kind != 3) begin
            send_item(MODE_ACK, rand_byte(), rand_count());
            void'(msg_lens.pop_front());
            queued_bytes -= len + (prefix_on ? PREFIX_BYTES : 0);
        end
    endtask

    task automatic random_phase(input int n);
        int         target;
        int         r;
        logic [2:0] m;
        target = items_sent + n;
        while (items_sent < target) begin
            no_gaps = ($urandom_range(9) < 3);
            r = $urandom_range(99);
            if (r < 46) begin
                write_message();
            end else if (r < 92) begin
                read_message();
            end else begin
                // Stray items never publish or release data, so message boundaries hold.
                repeat ($urandom_range(3, 1)) begin
                    m = 3'($urandom_range(7));
                    if (m == MODE_COMMIT || m == MODE_ACK) begin
                        m = MODE_UNUSED_A;
                    end
                    send_item(m, rand_byte(), rand_count());
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_mode       <= MODE_WSTART;
        i_data_byte  <= '0;
        i_byte_count <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_wdata  <= 1'b0;
        items_sent   = 0;
        queued_bytes = 0;
        prefix_on    = 1'b0;
        no_gaps      = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_prefix(1'b0);

        // Empty ring and no-op modes, then a write start for the largest length.
        send_item(MODE_RSTART, rand_byte(), '0);
        send_item(MODE_RBYTE, rand_byte(), rand_count());
        send_item(MODE_ACK, rand_byte(), rand_count());
        send_item(MODE_COMMIT, rand_byte(), rand_count());
        send_item(MODE_UNUSED_A, rand_byte(), rand_count());
        send_item(MODE_UNUSED_B, rand_byte(), rand_count());
        send_item(MODE_WSTART, rand_byte(), LEN_MAX);

        // A short message read first with too small a capacity.
        send_item(MODE_WSTART, rand_byte(), CNT_W'(2));
        repeat (2) send_item(MODE_WBYTE, rand_byte(), rand_count());
        send_item(MODE_COMMIT, rand_byte(), rand_count());
        send_item(MODE_RSTART, rand_byte(), '0);
        send_item(MODE_RSTART, rand_byte(), LEN_MAX);
        repeat (2) send_item(MODE_RBYTE, rand_byte(), rand_count());
        send_item(MODE_ACK, rand_byte(), rand_count());

        // Raw bytes that read back as an oversized length word once the prefix is on.
        send_item(MODE_WSTART, rand_byte(), CNT_W'(PREFIX_BYTES));
        repeat (PREFIX_BYTES) send_item(MODE_WBYTE, 8'hFF, rand_count());
        send_item(MODE_COMMIT, rand_byte(), rand_count());
        set_prefix(1'b1);
        send_item(MODE_RSTART, rand_byte(), LEN_MAX);
        send_item(MODE_ACK, rand_byte(), rand_count());

        send_item(MODE_WSTART, rand_byte(), LEN_MAX);
        send_item(MODE_WSTART, rand_byte(), CNT_W'(30));
        repeat (30) send_item(MODE_WBYTE, rand_byte(), rand_count());
        send_item(MODE_COMMIT, rand_byte(), rand_count());
        send_item(MODE_RSTART, rand_byte(), CNT_W'(29));
        send_item(MODE_RSTART, rand_byte(), CNT_W'(30));
        repeat (30) send_item(MODE_RBYTE, rand_byte(), rand_count());
        send_item(MODE_ACK, rand_byte(), rand_count());
        send_item(MODE_WSTART, rand_byte(), '0);
        send_item(MODE_COMMIT, rand_byte(), rand_count());
        send_item(MODE_RSTART, rand_byte(), '0);
        send_item(MODE_ACK, rand_byte(), rand_count());

        random_phase(PHASE_ITEMS);
        drain_ring();
        set_prefix(1'b0);
        random_phase(PHASE_ITEMS);
        drain_ring();
        set_prefix(1'b1);
        random_phase(PHASE_ITEMS);

        wait_idle();
        @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS ring_buffer_with_commit_and_ack");
        end else begin
            $display("FAIL ring_buffer_with_commit_and_ack");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/rbca_pkg.sv
rtl/core/rbca_dp.sv
rtl/core/rbca_ctrl.sv
rtl/core/ring_buffer_with_commit_and_ack.sv
sim/rbca_result_check.sv
sim/ring_buffer_with_commit_and_ack_tb.sv
